FILE: rtl/iprbl_pkg.sv
// ----------------------------------------------------------------------------
// iprbl_pkg
// Shared types, constants and helpers of the IPv4 range blocklist lookup.
// ----------------------------------------------------------------------------
package iprbl_pkg;

  localparam int MAX_RANGES = 256;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Datapath commands issued by the controller
  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_RD_CUR,
    CMD_RD_PREV,
    CMD_RD_MID,
    CMD_RD_LOPREV,
    CMD_SKIP,
    CMD_MARK_FIRST,
    CMD_ABSORB,
    CMD_WR_MERGED,
    CMD_COPY_DOWN,
    CMD_COUNT_J,
    CMD_START_SHIFT,
    CMD_COPY_UP,
    CMD_WR_INSERT,
    CMD_REFUSE,
    CMD_BSEARCH,
    CMD_HIT,
    CMD_EMIT
  } dp_cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    opcode_t op;
    logic    i_lt_n;
    logic    below;
    logic    touch;
    logic    merged;
    logic    full;
    logic    i_gt_first;
    logic    lo_lt_hi;
    logic    lo_zero;
    logic    out_free;
  } dp_status_t;

  // Network mask with the top plen bits set; lengths above 32 act as 32
  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [5:0] p;
    p = (plen > 6'd32) ? 6'd32 : plen;
    return ~(32'hFFFF_FFFF >> p);
  endfunction

endpackage

FILE: rtl/ipv4_range_blocklist_lookup.sv
// ----------------------------------------------------------------------------
// ipv4_range_blocklist_lookup
// Sorted table of disjoint IPv4 intervals with merge on add and lookup.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one word of opcode, address and
// prefix_len. opcode 0 clears the table, 1 adds the CIDR block
// address/prefix_len (merging overlapping or touching intervals), 2 looks
// up address. Output channel: out_valid/out_stall carry one result word per
// input word: hit, status (1 = add refused, table full) and range_count.
// Items are handled one at a time by a controller and a table memory
// with one read port, one write port and registered read. The next word
// is taken as soon as the result is placed in the output register, even
// while that result is still stalled. Reset empties the table at once
// (no clearing pass) and drops any pending result.
// ----------------------------------------------------------------------------
module ipv4_range_blocklist_lookup
  import iprbl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       opcode,
  input  logic [31:0]      address,
  input  logic [5:0]       prefix_len,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             hit,
  output logic             status,
  output logic [CNT_W-1:0] range_count
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       busy;

  assign in_stall = busy;

  iprbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (busy),
    .st       (st),
    .cmd      (cmd)
  );

  iprbl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .opcode      (opcode),
    .address     (address),
    .prefix_len  (prefix_len),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .status      (status),
    .range_count (range_count)
  );

endmodule

FILE: rtl/iprbl_ctrl.sv
// ----------------------------------------------------------------------------
// iprbl_ctrl
// Sequencer for clear, add (scan, merge, shift) and query (halving search).
// ----------------------------------------------------------------------------
module iprbl_ctrl
  import iprbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       busy,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_F_RD, S_F_CMP, S_L_RD, S_L_CMP, S_DECIDE,
    S_D_RD, S_D_WR, S_U_RD, S_U_WR, S_Q_CHK, S_Q_CMP, S_Q_HIT, S_EMIT
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Pick the command and the next state
  always_comb begin
    cmd        = CMD_IDLE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.op)
          OP_CLEAR: begin
            cmd        = CMD_CLEAR;
            state_next = S_EMIT;
          end
          OP_ADD:   state_next = S_F_RD;
          OP_QUERY: state_next = S_Q_CHK;
          default:  state_next = S_EMIT;
        endcase
      end
      S_F_RD: begin
        if (st.i_lt_n) begin
          cmd        = CMD_RD_CUR;
          state_next = S_F_CMP;
        end else begin
          cmd        = CMD_MARK_FIRST;
          state_next = S_L_RD;
        end
      end
      S_F_CMP: begin
        if (st.below) begin
          cmd        = CMD_SKIP;
          state_next = S_F_RD;
        end else begin
          cmd        = CMD_MARK_FIRST;
          state_next = S_L_RD;
        end
      end
      S_L_RD: begin
        if (st.i_lt_n) begin
          cmd        = CMD_RD_CUR;
          state_next = S_L_CMP;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_L_CMP: begin
        if (st.touch) begin
          cmd        = CMD_ABSORB;
          state_next = S_L_RD;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.merged) begin
          cmd        = CMD_WR_MERGED;
          state_next = S_D_RD;
        end else if (st.full) begin
          cmd        = CMD_REFUSE;
          state_next = S_EMIT;
        end else begin
          cmd        = CMD_START_SHIFT;
          state_next = S_U_RD;
        end
      end
      S_D_RD: begin
        if (st.i_lt_n) begin
          cmd        = CMD_RD_CUR;
          state_next = S_D_WR;
        end else begin
          cmd        = CMD_COUNT_J;
          state_next = S_EMIT;
        end
      end
      S_D_WR: begin
        cmd        = CMD_COPY_DOWN;
        state_next = S_D_RD;
      end
      S_U_RD: begin
        if (st.i_gt_first) begin
          cmd        = CMD_RD_PREV;
          state_next = S_U_WR;
        end else begin
          cmd        = CMD_WR_INSERT;
          state_next = S_EMIT;
        end
      end
      S_U_WR: begin
        cmd        = CMD_COPY_UP;
        state_next = S_U_RD;
      end
      S_Q_CHK: begin
        if (st.lo_lt_hi) begin
          cmd        = CMD_RD_MID;
          state_next = S_Q_CMP;
        end else if (st.lo_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd        = CMD_RD_LOPREV;
          state_next = S_Q_HIT;
        end
      end
      S_Q_CMP: begin
        cmd        = CMD_BSEARCH;
        state_next = S_Q_CHK;
      end
      S_Q_HIT: begin
        cmd        = CMD_HIT;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd        = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/iprbl_dp.sv
// ----------------------------------------------------------------------------
// iprbl_dp
// Interval table memory, scan cursors, search bounds and the result register.
// ----------------------------------------------------------------------------
module iprbl_dp
  import iprbl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_status_t       st,
  input  logic [1:0]       opcode,
  input  logic [31:0]      address,
  input  logic [5:0]       prefix_len,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             hit,
  output logic             status,
  output logic [CNT_W-1:0] range_count
);

  logic [63:0]      mem [MAX_RANGES];
  logic [31:0]      rd_low, rd_high;
  opcode_t          op;
  logic [31:0]      nlo, nhi, addr;
  logic [CNT_W-1:0] i, j, first, lo, hi, count;
  logic             res_hit, res_status;

  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] mid, i_prev, lo_prev, rsel;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] waddr;
  logic [63:0]      wdata;
  logic [31:0]      mask;

  assign mask    = prefix_mask(prefix_len);
  assign sum     = {1'b0, lo} + {1'b0, hi};
  assign mid     = sum[CNT_W:1];
  assign i_prev  = i - 1'b1;
  assign lo_prev = lo - 1'b1;

  // Status toward the controller
  always_comb begin
    st.op         = op;
    st.i_lt_n     = (i < count);
    st.below      = ({1'b0, rd_high} + 33'd1) < {1'b0, nlo};
    st.touch      = {1'b0, rd_low} <= ({1'b0, nhi} + 33'd1);
    st.merged     = (i > first);
    st.full       = (count >= CNT_W'(MAX_RANGES));
    st.i_gt_first = (i > first);
    st.lo_lt_hi   = (lo < hi);
    st.lo_zero    = (lo == '0);
    st.out_free   = !out_valid || !out_stall;
  end

  // Select read and write ports
  always_comb begin
    rd_en = 1'b1;
    case (cmd)
      CMD_RD_CUR:    rsel = i;
      CMD_RD_PREV:   rsel = i_prev;
      CMD_RD_MID:    rsel = mid;
      CMD_RD_LOPREV: rsel = lo_prev;
      default: begin
        rsel  = i;
        rd_en = 1'b0;
      end
    endcase
    wr_en = 1'b1;
    case (cmd)
      CMD_WR_MERGED, CMD_WR_INSERT: begin
        waddr = first[IDX_W-1:0];
        wdata = {nhi, nlo};
      end
      CMD_COPY_DOWN: begin
        waddr = j[IDX_W-1:0];
        wdata = {rd_high, rd_low};
      end
      CMD_COPY_UP: begin
        waddr = i[IDX_W-1:0];
        wdata = {rd_high, rd_low};
      end
      default: begin
        waddr = i[IDX_W-1:0];
        wdata = {rd_high, rd_low};
        wr_en = 1'b0;
      end
    endcase
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      {rd_high, rd_low} <= mem[rsel[IDX_W-1:0]];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op         <= opcode_t'(opcode);
        addr       <= address;
        nlo        <= address & mask;
        nhi        <= (address & mask) | ~mask;
        i          <= '0;
        lo         <= '0;
        hi         <= count;
        res_hit    <= 1'b0;
        res_status <= 1'b0;
      end
      CMD_SKIP:       i <= i + 1'b1;
      CMD_MARK_FIRST: first <= i;
      CMD_ABSORB: begin
        if (rd_low < nlo) nlo <= rd_low;
        if (rd_high > nhi) nhi <= rd_high;
        i <= i + 1'b1;
      end
      CMD_WR_MERGED: j <= first + 1'b1;
      CMD_COPY_DOWN: begin
        i <= i + 1'b1;
        j <= j + 1'b1;
      end
      CMD_START_SHIFT: i <= count;
      CMD_COPY_UP:     i <= i_prev;
      CMD_REFUSE:      res_status <= 1'b1;
      CMD_BSEARCH: begin
        if (rd_low <= addr) lo <= mid + 1'b1;
        else hi <= mid;
      end
      CMD_HIT: res_hit <= (rd_high >= addr);
      default: ;
    endcase
  end

  // Interval count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        CMD_CLEAR:     count <= '0;
        CMD_COUNT_J:   count <= j;
        CMD_WR_INSERT: count <= count + 1'b1;
        default: ;
      endcase
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid   <= 1'b1;
      hit         <= res_hit;
      status      <= res_status;
      range_count <= count;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_CLEAR |=> count == '0)
    else $error("count not zero after clear");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("count above table size");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EMIT |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_COPY_UP |-> i > first)
    else $error("shift below insert point");
`endif

endmodule

FILE: tb/ipv4_range_blocklist_lookup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_range_blocklist_lookup_checker
// Watches both channels of the range blocklist, keeps its own copy of the
// interval table, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module ipv4_range_blocklist_lookup_checker
  import iprbl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       opcode,
  input  logic [31:0]      address,
  input  logic [5:0]       prefix_len,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             hit,
  input  logic             status,
  input  logic [CNT_W-1:0] range_count,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    logic             hit;
    logic             status;
    logic [CNT_W-1:0] count;
  } lookup_result_t;

  logic [31:0]    span_lo [MAX_RANGES];
  logic [31:0]    span_hi [MAX_RANGES];
  int             span_cnt;
  lookup_result_t expected_q[$];

  assign pending = expected_q.size();

  // Binary search for the last interval starting at or below addr
  function automatic logic lookup_addr(input logic [31:0] addr);
    int lo, hi, mid;
    lo = 0;
    hi = span_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (span_lo[mid] <= addr) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return 1'b0;
    return span_hi[lo - 1] >= addr;
  endfunction

  // Insert a prefix block, merging overlapping or touching intervals
  function automatic logic insert_block(input logic [31:0] addr, input logic [5:0] plen);
    logic [31:0] mask, nlo, nhi;
    int          p, first, last, n, i;
    p = (plen > 6'd32) ? 32 : int'(plen);
    mask = (p == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> p);
    nlo = addr & mask;
    nhi = nlo | ~mask;
    n = span_cnt;
    first = 0;
    while (first < n && {1'b0, span_hi[first]} + 33'd1 < {1'b0, nlo}) first++;
    last = first;
    while (last < n && {1'b0, span_lo[last]} <= {1'b0, nhi} + 33'd1) last++;
    if (last > first) begin
      if (span_lo[first] < nlo) nlo = span_lo[first];
      if (span_hi[last - 1] > nhi) nhi = span_hi[last - 1];
      span_lo[first] = nlo;
      span_hi[first] = nhi;
      for (i = last; i < n; i++) begin
        span_lo[first + 1 + i - last] = span_lo[i];
        span_hi[first + 1 + i - last] = span_hi[i];
      end
      span_cnt = n - (last - first) + 1;
      return 1'b1;
    end
    if (n >= MAX_RANGES) return 1'b0;
    for (i = n; i > first; i--) begin
      span_lo[i] = span_lo[i - 1];
      span_hi[i] = span_hi[i - 1];
    end
    span_lo[first] = nlo;
    span_hi[first] = nhi;
    span_cnt = n + 1;
    return 1'b1;
  endfunction

  // Predict on accepted input words, compare on accepted output words
  always @(posedge clk) begin
    lookup_result_t r, e;
    if (rst) begin
      span_cnt = 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        r.hit = 1'b0;
        r.status = 1'b0;
        case (opcode_t'(opcode))
          OP_CLEAR: span_cnt = 0;
          OP_ADD:   r.status = !insert_block(address, prefix_len);
          OP_QUERY: r.hit = lookup_addr(address);
          default:  ;
        endcase
        r.count = span_cnt[CNT_W-1:0];
        expected_q = {expected_q, r};
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (hit !== e.hit || status !== e.status || range_count !== e.count)
            fail_count <= fail_count + 1;
          if (hit !== e.hit) $error("hit: expected %0d actual %0d", e.hit, hit);
          if (status !== e.status)
            $error("status: expected %0d actual %0d", e.status, status);
          if (range_count !== e.count)
            $error("range_count: expected %0d actual %0d", e.count, range_count);
        end
      end
    end
  end

endmodule

FILE: tb/ipv4_range_blocklist_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_range_blocklist_lookup_tb
// Drives clear, add, query and unused words with random gaps and output
// stalls, including a long hold-off that backs up the input; the checker
// predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module ipv4_range_blocklist_lookup_tb;
  import iprbl_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       opcode = OP_CLEAR;
  logic [31:0]      address = '0;
  logic [5:0]       prefix_len = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             hit;
  logic             status;
  logic [CNT_W-1:0] range_count;
  int               fail_count;
  int               pending;
  logic             hold_off = 1'b0;
  logic [31:0]      recent_addr [8];

  always #5 clk = ~clk;

  ipv4_range_blocklist_lookup u_dut (.*);

  ipv4_range_blocklist_lookup_checker u_checker (.*);

  // Random gap length: mostly short, sometimes long
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  // Offer one word and hold it until accepted; valid drops in the next gap
  task automatic send_word(input opcode_t op, input logic [31:0] addr,
                           input logic [5:0] plen);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    address <= addr;
    prefix_len <= plen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Pick an address near previously used ones to reach merges and hits
  function automatic logic [31:0] near_addr();
    logic [31:0] a;
    a = recent_addr[$urandom_range(0, 7)];
    case ($urandom_range(0, 3))
      0: return a;
      1: return a + $urandom_range(0, 300);
      2: return a - $urandom_range(0, 300);
      default: return $urandom();
    endcase
  endfunction

  // Receiver stalls; a long hold-off overrides at the requested time
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if ($urandom_range(0, 3) == 0) out_stall <= 1'b1;
      else out_stall <= 1'b0;
    end
  end

  initial begin
    int          k, mode;
    logic [31:0] a;
    for (k = 0; k < 8; k++) recent_addr[k] = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, touching and merging blocks
    send_word(OP_QUERY, 32'h0, 6'd0);
    send_word(OP_QUERY, 32'hFFFF_FFFF, 6'd0);
    send_word(OP_ADD, 32'h0A00_00FF, 6'd24);
    send_word(OP_QUERY, 32'h0A00_0000, 6'd0);
    send_word(OP_QUERY, 32'h0A00_00FF, 6'd0);
    send_word(OP_QUERY, 32'h0A00_0100, 6'd0);
    send_word(OP_ADD, 32'h0A00_0100, 6'd24);
    send_word(OP_ADD, 32'h0A00_0300, 6'd24);
    send_word(OP_ADD, 32'hFFFF_FFFF, 6'd32);
    send_word(OP_ADD, 32'h0000_0000, 6'd63);
    send_word(OP_ADD, 32'h0A00_0200, 6'd40);
    send_word(OP_QUERY, 32'hFFFF_FFFF, 6'd0);
    send_word(OP_NONE, 32'h1234_5678, 6'd7);
    send_word(OP_ADD, 32'h0A00_0000, 6'd16);
    send_word(OP_ADD, 32'h5555_5555, 6'd0);
    send_word(OP_QUERY, 32'h8000_0000, 6'd0);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 6'd63);
    send_word(OP_QUERY, 32'h8000_0000, 6'd0);

    // Fill the table to full with disjoint single addresses, then one add that is refused and two that merge
    for (k = 0; k < MAX_RANGES; k++) send_word(OP_ADD, k * 4, 6'd32);
    send_word(OP_ADD, 32'h0001_0000, 6'd32);
    send_word(OP_ADD, 32'h0000_0001, 6'd32);
    send_word(OP_ADD, 32'h0000_0005, 6'd31);

    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (k = 0; k < 20; k++) send_word(OP_QUERY, k * 4, 6'd0);
    join
    send_word(OP_CLEAR, 32'h0, 6'd0);

    // Random part: adds and queries around recent addresses, with some unused and clear words
    for (k = 0; k < 1600; k++) begin
      mode = $urandom_range(0, 99);
      if (mode < 45) begin
        a = near_addr();
        recent_addr[$urandom_range(0, 7)] = a;
        send_word(OP_ADD, a, (mode < 3) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(16, 32)));
      end else if (mode < 93) begin
        send_word(OP_QUERY, near_addr(), 6'($urandom_range(0, 63)));
      end else if (mode < 96) begin
        send_word(OP_NONE, $urandom(), 6'($urandom_range(0, 63)));
      end else begin
        send_word(OP_CLEAR, $urandom(), 6'($urandom_range(0, 63)));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
